// ===== design/tbm_pkg.sv =====
// ----------------------------------------------------------------------------
// tbm_pkg
// Shared constants, opcode codes and the control word of the pattern matcher.
// ----------------------------------------------------------------------------
package tbm_pkg;

	localparam int PATTERN_MAX   = 64;
	localparam int ALPHABET_SIZE = 256;
	localparam int IDX_W         = 6;
	localparam int LEN_W         = 7;
	localparam int BYTE_W        = 8;
	localparam int POS_W         = 32;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_TEXT    = 2'd1,
		OP_RESTART = 2'd2,
		OP_CLEAR   = 2'd3
	} tbm_opcode_t;

	// one operation leaving the input register, already qualified by advance
	typedef struct packed {
		logic              load;
		logic              text;
		logic              restart;
		logic              clear;
		logic [IDX_W-1:0]  idx;
		logic [BYTE_W-1:0] data;
	} tbm_ctl_t;

endpackage

// ===== design/tbm_table.sv =====
// ----------------------------------------------------------------------------
// tbm_table
// Last-occurrence table: one write and one registered read per cycle, with
// per-entry valid bits for a whole-table clear and a write-to-read bypass.
// ----------------------------------------------------------------------------
module tbm_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [tbm_pkg::BYTE_W-1:0]   rd_addr,
	input  tbm_pkg::tbm_ctl_t            ctl,
	input  logic [tbm_pkg::LEN_W-1:0]    len,
	output logic [tbm_pkg::LEN_W-1:0]    lo
);
	import tbm_pkg::*;

	logic [LEN_W-1:0]         lo_mem [ALPHABET_SIZE];
	logic [ALPHABET_SIZE-1:0] vld_q;
	logic [LEN_W-1:0]         rd_q;
	logic [BYTE_W-1:0]        addr_q;
	logic                     byp_q;
	logic [LEN_W-1:0]         byp_val_q;
	logic                     wr_en;
	logic [LEN_W-1:0]         wr_val;

	assign wr_val = LEN_W'(ctl.idx) + LEN_W'(1);
	assign wr_en  = ctl.load && (wr_val < len);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			lo_mem[ctl.data] <= wr_val;
		end
		if (rd_en) begin
			rd_q      <= lo_mem[rd_addr];
			addr_q    <= rd_addr;
			// write landing on the same edge as the read
			byp_q     <= wr_en && (ctl.data == rd_addr);
			byp_val_q <= wr_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ctl.clear) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[ctl.data] <= 1'b1;
		end
	end

	always_comb begin
		if (!vld_q[addr_q]) begin
			lo = '0;
		end else if (byp_q) begin
			lo = byp_val_q;
		end else begin
			lo = rd_q;
		end
	end

endmodule

// ===== design/tbm_pattern.sv =====
// ----------------------------------------------------------------------------
// tbm_pattern
// Pattern store, text window aligned to the pattern length and the parallel
// window compare.
// ----------------------------------------------------------------------------
module tbm_pattern (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tbm_pkg::tbm_ctl_t          ctl,
	input  logic [tbm_pkg::LEN_W-1:0]  len,
	output logic                       hit
);
	import tbm_pkg::*;

	logic [BYTE_W-1:0]      store_q [PATTERN_MAX];
	// win_q[k] sits under pattern byte k, so win_q[m-1] is the newest text byte
	logic [BYTE_W-1:0]      win_q   [PATTERN_MAX];
	// window once the current text byte is taken in at slot m-1
	logic [BYTE_W-1:0]      win_nx  [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] eq;

	always_comb begin
		for (int k = 0; k < PATTERN_MAX-1; k++) begin
			win_nx[k] = (LEN_W'(k + 1) == len) ? ctl.data : win_q[k+1];
		end
		win_nx[PATTERN_MAX-1] = ctl.data;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			store_q[ctl.idx] <= ctl.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				win_q[k] <= '0;
			end
		end else if (ctl.restart) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				win_q[k] <= '0;
			end
		end else if (ctl.text) begin
			win_q <= win_nx;
		end
	end

	always_comb begin
		for (int k = 0; k < PATTERN_MAX; k++) begin
			eq[k] = (LEN_W'(k) >= len) || (win_nx[k] == store_q[k]);
		end
	end

	assign hit = &eq;

endmodule

// ===== design/tuned_boyer_moore_matcher.sv =====
// ----------------------------------------------------------------------------
// tuned_boyer_moore_matcher
// Exact pattern search over a byte stream with bad-character alignment shifts.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------
//   cfg     | cfg_valid/cfg_ready  | cfg_data (pattern length)
//   in      | in_valid/in_stall    | opcode, pattern_index, data_byte
//   out     | out_valid/out_stall  | match_position, match_count
//
// One item per cycle while the input is not stalled; an item sits in the
// input register, where the table read, window compare and alignment update
// are done, and a match lands in the output register the cycle after.
// The input stalls only while a match waits in that register and the output
// is stalled. Length writes are taken while the input register is empty.
// Reset clears the table valid bits, window, counters and sets length 1.
// ----------------------------------------------------------------------------
module tuned_boyer_moore_matcher (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tbm_pkg::LEN_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  opcode,
	input  logic [tbm_pkg::IDX_W-1:0]   pattern_index,
	input  logic [tbm_pkg::BYTE_W-1:0]  data_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [tbm_pkg::POS_W-1:0]   match_position,
	output logic [tbm_pkg::POS_W-1:0]   match_count
);
	import tbm_pkg::*;

	logic              valid_s1;
	tbm_opcode_t       opcode_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [BYTE_W-1:0] data_s1;

	logic [LEN_W-1:0]  len_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  align_q;
	logic [POS_W-1:0]  end_q;
	logic [POS_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic [POS_W-1:0]  position_q;
	logic [POS_W-1:0]  count_q;

	logic              accept;
	logic              cfg_we;
	logic [LEN_W-1:0]  cfg_len;
	logic              at_end;
	logic              hit;
	logic              produce;
	logic              out_free;
	logic              adv;
	logic [LEN_W-1:0]  lo;
	logic [LEN_W-1:0]  shift;
	logic [POS_W-1:0]  cnt_next;
	tbm_ctl_t          ctl;

	assign accept    = in_valid && !in_stall;
	assign cfg_ready = !valid_s1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_comb begin
		if (cfg_data == '0) begin
			cfg_len = LEN_W'(1);
		end else if (cfg_data > LEN_W'(PATTERN_MAX)) begin
			cfg_len = LEN_W'(PATTERN_MAX);
		end else begin
			cfg_len = cfg_data;
		end
	end

	assign at_end   = (pos_q == end_q);
	assign produce  = valid_s1 && (opcode_s1 == OP_TEXT) && at_end && hit;
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && (!produce || out_free);
	assign in_stall = valid_s1 && !adv;

	// stale entries from a longer pattern shift by one
	assign shift    = (lo >= len_q) ? LEN_W'(1) : (len_q - lo);
	assign cnt_next = (&cnt_q) ? cnt_q : (cnt_q + POS_W'(1));

	always_comb begin
		ctl         = '0;
		ctl.load    = adv && (opcode_s1 == OP_LOAD);
		ctl.text    = adv && (opcode_s1 == OP_TEXT);
		ctl.restart = (adv && (opcode_s1 == OP_RESTART)) || cfg_we;
		ctl.clear   = adv && (opcode_s1 == OP_CLEAR);
		ctl.idx     = idx_s1;
		ctl.data    = data_s1;
	end

	tbm_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (data_byte),
		.ctl     (ctl),
		.len     (len_q),
		.lo      (lo)
	);

	tbm_pattern u_pattern (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.len    (len_q),
		.hit    (hit)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= tbm_opcode_t'(opcode);
			idx_s1    <= pattern_index;
			data_s1   <= data_byte;
		end
		if (produce && adv) begin
			position_q <= align_q;
			count_q    <= cnt_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (produce && adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= LEN_W'(1);
			pos_q   <= '0;
			align_q <= '0;
			end_q   <= '0;
			cnt_q   <= '0;
		end else if (cfg_we) begin
			len_q   <= cfg_len;
			pos_q   <= '0;
			align_q <= '0;
			end_q   <= POS_W'(cfg_len - LEN_W'(1));
			cnt_q   <= '0;
		end else if (adv) begin
			case (opcode_s1)
				OP_RESTART: begin
					pos_q   <= '0;
					align_q <= '0;
					end_q   <= POS_W'(len_q - LEN_W'(1));
					cnt_q   <= '0;
				end
				OP_TEXT: begin
					pos_q <= pos_q + POS_W'(1);
					if (at_end) begin
						align_q <= align_q + POS_W'(shift);
						end_q   <= end_q + POS_W'(shift);
					end
					if (produce) begin
						cnt_q <= cnt_next;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign match_position = position_q;
	assign match_count    = count_q;

	// alignment end always leads the alignment start by the length less one
	a_end_tracks_align: assert property (@(posedge clk) disable iff (!arst_n)
		(end_q - align_q) == POS_W'(len_q - LEN_W'(1)))
		else $error("alignment end out of step with alignment start");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (count_q != '0))
		else $error("result shown with zero match count");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (opcode_s1 == OP_TEXT) && !cfg_we) |=> (cnt_q >= $past(cnt_q)))
		else $error("match count went down on a text byte");

	a_match_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(produce && adv) |=> (out_valid_q && (position_q == $past(align_q))))
		else $error("match not captured at current alignment");

endmodule
